@@ rtl/ntp_pkg.sv @@
package ntp_pkg;

   // Default longest token, in characters, before the token is an error
   localparam int MAX_TOKEN_LEN_DEF = 127;

   // Widths of the token state and result fields
   localparam int CHAR_W  = 8;
   localparam int ACC_W   = 32;
   localparam int FCNT_W  = 4;
   localparam int CCNT_W  = 8;
   localparam int LEN_W   = 7;
   localparam int NTYPE_W = 3;

   // Character count saturates here; the reported length is capped here
   localparam logic [CCNT_W-1:0] CCNT_SAT = 8'd255;
   localparam logic [CCNT_W-1:0] LEN_CAP  = 8'd127;
   localparam logic [FCNT_W-1:0] FRAC_MAX = 4'd9;

   // Target number types
   localparam logic [NTYPE_W-1:0] NT_U8    = 3'd0;
   localparam logic [NTYPE_W-1:0] NT_U16   = 3'd1;
   localparam logic [NTYPE_W-1:0] NT_U32   = 3'd2;
   localparam logic [NTYPE_W-1:0] NT_S8    = 3'd3;
   localparam logic [NTYPE_W-1:0] NT_S16   = 3'd4;
   localparam logic [NTYPE_W-1:0] NT_S32   = 3'd5;
   localparam logic [NTYPE_W-1:0] NT_FLOAT = 3'd6;
   localparam logic [NTYPE_W-1:0] NT_RESET = NT_U32;

   // Characters with a meaning of their own
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LF_CH = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

   typedef enum logic [3:0] {
      ST_START   = 4'd0,
      ST_NEG     = 4'd1,
      ST_BIN     = 4'd2,
      ST_HEX     = 4'd3,
      ST_FPOS    = 4'd4,
      ST_FNEG    = 4'd5,
      ST_ERR     = 4'd6,
      ST_ZERO    = 4'd8,
      ST_HEX_OK  = 4'd9,
      ST_OCT_OK  = 4'd10,
      ST_BIN_OK  = 4'd11,
      ST_NEG_OK  = 4'd12,
      ST_POS_OK  = 4'd13,
      ST_FPOS_OK = 4'd14,
      ST_FNEG_OK = 4'd15
   } parse_state_type;

   typedef enum logic [1:0] {
      BASE_2  = 2'd0,
      BASE_8  = 2'd1,
      BASE_10 = 2'd2,
      BASE_16 = 2'd3
   } base_type;

   // Running state of the token being parsed
   typedef struct packed {
      parse_state_type       state;
      logic [ACC_W-1:0]      int_acc;
      logic [ACC_W-1:0]      frac_acc;
      logic [FCNT_W-1:0]     frac_cnt;
      logic [CCNT_W-1:0]     char_cnt;
   } token_type;

   // One result transaction
   typedef struct packed {
      logic                  ok;
      logic                  negative;
      logic [ACC_W-1:0]      magnitude;
      logic [ACC_W-1:0]      frac_value;
      logic [FCNT_W-1:0]     frac_digits;
      logic                  is_fraction;
      logic [LEN_W-1:0]      length;
   } result_type;

   typedef struct packed {
      logic                  valid;
      logic [3:0]            value;
   } digit_type;

   typedef struct packed {
      logic                  ovf;
      logic [ACC_W-1:0]      value;
   } push_type;

   localparam token_type TOKEN_CLEAR = '{
      state: ST_START, int_acc: '0, frac_acc: '0, frac_cnt: '0, char_cnt: '0};

   function automatic logic [4:0] base_value(input base_type base);
      logic [4:0] v;
      case (base)
         BASE_2:  v = 5'd2;
         BASE_8:  v = 5'd8;
         BASE_10: v = 5'd10;
         BASE_16: v = 5'd16;
         default: v = 5'd10;
      endcase
      return v;
   endfunction

   // Decode one digit character in the given base
   function automatic digit_type digit_of(input logic [CHAR_W-1:0] c, input base_type base);
      logic [4:0] d;
      logic       hit;
      digit_type  r;
      d   = '0;
      hit = 1'b0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d   = 5'(c - CH_ZERO);
         hit = 1'b1;
      end else if (base == BASE_16 && c >= CH_LA && c <= CH_LF_CH) begin
         d   = 5'(c - CH_LA) + 5'd10;
         hit = 1'b1;
      end else if (base == BASE_16 && c >= CH_UA && c <= CH_UF) begin
         d   = 5'(c - CH_UA) + 5'd10;
         hit = 1'b1;
      end
      r.valid = hit && (d < base_value(base));
      r.value = d[3:0];
      return r;
   endfunction

   // acc * base + digit with overflow past 32 bits
   function automatic push_type acc_push(input logic [ACC_W-1:0] acc, input base_type base,
                                         input logic [3:0] digit);
      logic [ACC_W+3:0] v;
      push_type         r;
      case (base)
         BASE_2:  v = {3'b000, acc, 1'b0};
         BASE_8:  v = {1'b0, acc, 3'b000};
         BASE_10: v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
         BASE_16: v = {acc, 4'b0000};
         default: v = '0;
      endcase
      v       = v + (ACC_W+4)'(digit);
      r.ovf   = |v[ACC_W+3:ACC_W];
      r.value = v[ACC_W-1:0];
      return r;
   endfunction

endpackage

@@ rtl/ntp_step.sv @@
module ntp_step #(
   parameter int MAX_TOKEN_LEN = ntp_pkg::MAX_TOKEN_LEN_DEF
) (
   input  ntp_pkg::token_type                cur,
   input  logic [ntp_pkg::CHAR_W-1:0]        ch,
   input  logic [ntp_pkg::NTYPE_W-1:0]       number_type,
   output ntp_pkg::token_type                nxt,
   output ntp_pkg::result_type               res,
   output logic                              is_term
);
   import ntp_pkg::*;

   parse_state_type        st;
   parse_state_type        tgt;
   logic                   do_int;
   logic                   do_frac;
   base_type               base;
   digit_type              dig;
   digit_type              dig10;
   push_type               ipush;
   push_type               fpush;
   logic [CCNT_W-1:0]      cnt;
   logic                   ok;
   logic                   neg;
   logic                   frac;
   logic [ACC_W-1:0]       m;

   // Detect the end-of-token characters
   assign is_term = (ch == CH_NUL) || (ch == CH_SPACE) || (ch == CH_TAB) ||
                    (ch == CH_CR) || (ch == CH_LF) || (ch == CH_HASH);

   // Pick the action for this character from the current state
   always_comb begin
      st      = cur.state;
      tgt     = cur.state;
      do_int  = 1'b0;
      do_frac = 1'b0;
      base    = BASE_10;
      case (cur.state)
         ST_START: begin
            if (ch == CH_MINUS) st = ST_NEG;
            else if (ch == CH_ZERO) st = ST_ZERO;
            else if (ch == CH_POINT) st = ST_FPOS;
            else begin
               do_int = 1'b1;
               tgt    = ST_POS_OK;
            end
         end
         ST_ZERO: begin
            if (ch == CH_LX) st = ST_HEX;
            else if (ch == CH_LB) st = ST_BIN;
            else if (ch == CH_POINT) st = ST_FPOS;
            else begin
               do_int = 1'b1;
               base   = BASE_8;
               tgt    = ST_OCT_OK;
            end
         end
         ST_NEG, ST_NEG_OK: begin
            if (ch == CH_POINT) st = ST_FNEG;
            else begin
               do_int = 1'b1;
               tgt    = ST_NEG_OK;
            end
         end
         ST_POS_OK: begin
            if (ch == CH_POINT) st = ST_FPOS;
            else begin
               do_int = 1'b1;
               tgt    = ST_POS_OK;
            end
         end
         ST_HEX, ST_HEX_OK: begin
            do_int = 1'b1;
            base   = BASE_16;
            tgt    = ST_HEX_OK;
         end
         ST_OCT_OK: begin
            do_int = 1'b1;
            base   = BASE_8;
            tgt    = ST_OCT_OK;
         end
         ST_BIN, ST_BIN_OK: begin
            do_int = 1'b1;
            base   = BASE_2;
            tgt    = ST_BIN_OK;
         end
         ST_FPOS, ST_FPOS_OK: begin
            do_frac = 1'b1;
            tgt     = ST_FPOS_OK;
         end
         ST_FNEG, ST_FNEG_OK: begin
            do_frac = 1'b1;
            tgt     = ST_FNEG_OK;
         end
         ST_ERR: st = ST_ERR;
         default: st = ST_ERR;
      endcase
   end

   // Digit decode and accumulate
   assign dig   = digit_of(ch, base);
   assign dig10 = digit_of(ch, BASE_10);
   assign ipush = acc_push(cur.int_acc, base, dig.value);
   assign fpush = acc_push(cur.frac_acc, BASE_10, dig10.value);

   // Range check of the finished token against the target type
   always_comb begin
      m    = cur.int_acc;
      neg  = 1'b0;
      frac = 1'b0;
      ok   = 1'b0;
      case (cur.state)
         ST_ZERO, ST_POS_OK, ST_HEX_OK, ST_OCT_OK, ST_BIN_OK: begin
            ok = (number_type == NT_U8 && m <= 32'd255) ||
                 (number_type == NT_U16 && m <= 32'd65535) ||
                 (number_type == NT_U32) ||
                 (number_type == NT_S8 && m <= 32'd127) ||
                 (number_type == NT_S16 && m <= 32'd32767) ||
                 (number_type == NT_S32 && m <= 32'h7FFF_FFFF) ||
                 (number_type == NT_FLOAT);
         end
         ST_NEG_OK: begin
            neg = 1'b1;
            ok  = (number_type == NT_S8 && m <= 32'd128) ||
                  (number_type == NT_S16 && m <= 32'd32768) ||
                  (number_type == NT_S32 && m <= 32'h8000_0000) ||
                  (number_type == NT_FLOAT);
         end
         ST_FPOS, ST_FPOS_OK: begin
            frac = 1'b1;
            ok   = (number_type == NT_FLOAT);
         end
         ST_FNEG, ST_FNEG_OK: begin
            neg  = 1'b1;
            frac = 1'b1;
            ok   = (number_type == NT_FLOAT);
         end
         default: ok = 1'b0;
      endcase
   end

   // Build the next token state and the result
   always_comb begin
      nxt = cur;
      res = '0;
      cnt = (cur.char_cnt != CCNT_SAT) ? cur.char_cnt + 1'b1 : cur.char_cnt;
      if (is_term) begin
         nxt = TOKEN_CLEAR;
         if (ok) begin
            res.ok          = 1'b1;
            res.negative    = neg;
            res.magnitude   = cur.int_acc;
            res.frac_value  = cur.frac_acc;
            res.frac_digits = cur.frac_cnt;
            res.is_fraction = frac;
            res.length      = (cur.char_cnt > LEN_CAP) ? LEN_CAP[LEN_W-1:0]
                                                       : cur.char_cnt[LEN_W-1:0];
         end
      end else begin
         nxt.char_cnt = cnt;
         nxt.state    = st;
         if (do_int) begin
            if (!dig.valid || ipush.ovf) begin
               nxt.state = ST_ERR;
            end else begin
               nxt.int_acc = ipush.value;
               nxt.state   = tgt;
            end
         end
         if (do_frac) begin
            if (!dig10.valid || fpush.ovf || cur.frac_cnt >= FRAC_MAX) begin
               nxt.state = ST_ERR;
            end else begin
               nxt.frac_acc = fpush.value;
               nxt.frac_cnt = cur.frac_cnt + 1'b1;
               nxt.state    = tgt;
            end
         end
         if ({1'b0, cnt} > (CCNT_W+1)'(MAX_TOKEN_LEN)) begin
            nxt.state = ST_ERR;
         end
      end
   end

endmodule

@@ rtl/numeric_token_parser.sv @@
// Numeric token parser: takes one ASCII character per request transaction and
// returns one response transaction for each token terminator (NUL, space,
// tab, CR, LF or '#'). Decimal, negative decimal, 0x hex, 0b binary, leading-0
// octal and decimal fractions are recognized.
// Request channel: req_valid/req_stall carry req_ch. Response channel:
// rsp_valid/rsp_stall carry ok, sign, magnitude, fraction value and digit
// count, fraction flag and token length; when ok is low the rest reads zero.
// csr_wr_en/csr_wr_data set the target type (0 u8, 1 u16, 2 u32, 3 s8,
// 4 s16, 5 s32, 6 float); write it only while no token is in flight.
// A terminator's response passes through the input register, then one pass
// of parse logic into the result register, which drives the response.
// Throughput: one character per cycle while req_stall is low, set by the
// combinational update of the token state. While a response waits under
// rsp_stall, non-terminator characters still flow; a terminator holds in
// the input register and req_stall rises until the response slot frees.
// Reset clears the token state, both registers' valid flags and sets the
// target type to u32.
module numeric_token_parser #(
   parameter int MAX_TOKEN_LEN = ntp_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ntp_pkg::CHAR_W-1:0]        req_ch,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_ok,
   output logic                              rsp_negative,
   output logic [ntp_pkg::ACC_W-1:0]         rsp_magnitude,
   output logic [ntp_pkg::ACC_W-1:0]         rsp_frac_value,
   output logic [ntp_pkg::FCNT_W-1:0]        rsp_frac_digits,
   output logic                              rsp_is_fraction,
   output logic [ntp_pkg::LEN_W-1:0]         rsp_length,
   input  logic                              csr_wr_en,
   input  logic [ntp_pkg::NTYPE_W-1:0]       csr_wr_data
);
   import ntp_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [CHAR_W-1:0]      in_ch_ff;
   token_type              tok_ff;
   token_type              tok_in;
   result_type             res_ff;
   result_type             res_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [NTYPE_W-1:0]     ntype_ff;
   logic                   is_term;
   logic                   fire;
   logic                   req_take;

   ntp_step #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_step (
      .cur         (tok_ff),
      .ch          (in_ch_ff),
      .number_type (ntype_ff),
      .nxt         (tok_in),
      .res         (res_in),
      .is_term     (is_term)
   );

   // Advance the input register unless a terminator meets a held response
   assign fire     = in_valid_ff && !(is_term && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire && is_term) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   // Control state and token state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tok_ff       <= TOKEN_CLEAR;
         ntype_ff     <= NT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) tok_ff <= tok_in;
         if (csr_wr_en) ntype_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) in_ch_ff <= req_ch;
      if (fire && is_term) res_ff <= res_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_ok          = res_ff.ok;
   assign rsp_negative    = res_ff.negative;
   assign rsp_magnitude   = res_ff.magnitude;
   assign rsp_frac_value  = res_ff.frac_value;
   assign rsp_frac_digits = res_ff.frac_digits;
   assign rsp_is_fraction = res_ff.is_fraction;
   assign rsp_length      = res_ff.length;

endmodule
